### rtl/core/dds_sweep_ramp_planner_macros.svh
// Assertion macros shared by the sweep planner modules.
// No dependencies.
`ifndef DDS_SWEEP_RAMP_PLANNER_MACROS_SVH
`define DDS_SWEEP_RAMP_PLANNER_MACROS_SVH
// implication checked every clock outside reset
`define DSRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define DSRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

### rtl/core/dsrp_pkg.sv
// Shared types and constants for the sweep ramp planner.
// No dependencies.
package dsrp_pkg;
    localparam int unsigned SYSCLK_W     = 30;
    localparam int unsigned FREQ_W       = 32;
    localparam int unsigned SYSCLK_RESET = 1000000000;
    localparam int unsigned QDEPTH_DEF   = 2;
    localparam logic [31:0] BASE_NS      = 32'd4000000000;
    localparam logic [15:0] MAX_PERIOD   = 16'hFFFF;

    typedef enum logic [1:0] {
        UNIT_S  = 2'd0,
        UNIT_MS = 2'd1,
        UNIT_US = 2'd2,
        UNIT_NS = 2'd3
    } t_unit;

    // classified job passed front to back
    typedef struct packed {
        logic        bad;
        logic        rep;
        logic [31:0] start_f;
        logic [31:0] stop_f;
        logic [61:0] ns;
    } t_job;

    typedef struct packed {
        logic        status;
        logic [31:0] start_word;
        logic [31:0] end_word;
        logic [31:0] word_step;
        logic [15:0] step_period;
        logic        rep;
    } t_res;
endpackage

### rtl/core/dsrp_front.sv
// Front end: accepts requests, screens them, converts the duration to ns.
// Depends on dsrp_pkg.
module dsrp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic [31:0]       i_start_freq_hz,
    input  logic [31:0]       i_stop_freq_hz,
    input  logic [31:0]       i_sweep_duration,
    input  logic [1:0]        i_time_unit,
    input  logic              i_repeat_sweep,
    output logic              o_valid,
    input  logic              i_ready,
    output dsrp_pkg::t_job    o_job
);
    logic           r_valid;
    dsrp_pkg::t_job r_job;
    logic [61:0]    w_ns;
    logic [29:0]    w_mul;

    always_comb begin
        case (dsrp_pkg::t_unit'(i_time_unit))
            dsrp_pkg::UNIT_S:  w_mul = 30'd1000000000;
            dsrp_pkg::UNIT_MS: w_mul = 30'd1000000;
            dsrp_pkg::UNIT_US: w_mul = 30'd1000;
            default:           w_mul = 30'd1;
        endcase
        w_ns = 62'(i_sweep_duration) * 62'(w_mul);
    end

    assign o_full  = r_valid && !i_ready;
    assign o_valid = r_valid;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push && !o_full) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_push && !o_full) begin
            r_job.bad     <= (i_sweep_duration == '0) || (i_start_freq_hz == '0)
                             || (i_stop_freq_hz <= i_start_freq_hz);
            r_job.rep     <= i_repeat_sweep;
            r_job.start_f <= i_start_freq_hz;
            r_job.stop_f  <= i_stop_freq_hz;
            r_job.ns      <= w_ns;
        end
    end
endmodule

### rtl/core/dsrp_queue.sv
// Short queue between front and back ends.
// Depends on dsrp_pkg and the assertion macros.
`include "dds_sweep_ramp_planner_macros.svh"
module dsrp_queue #(
    parameter int unsigned DEPTH = dsrp_pkg::QDEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  dsrp_pkg::t_job i_data,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_rd,
    output dsrp_pkg::t_job o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    dsrp_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wp, r_rp;
    logic [AW:0]    r_cnt;
    logic           w_wr, w_rd;

    assign o_ready = r_cnt != (AW+1)'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign w_wr    = i_wr && o_ready;
    assign w_rd    = i_rd && o_valid;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            if (w_rd) r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
        if (w_wr) r_mem[r_wp] <= i_data;
    end

    `DSRP_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= (AW+1)'(DEPTH), "queue overfull")
    `DSRP_ASSERT_NXT(a_fill, i_clk, i_rst_n, w_wr && !w_rd, r_cnt == $past(r_cnt) + 1'b1, "count slip")
    `DSRP_ASSERT_IMP(a_ptr_eq, i_clk, i_rst_n, r_cnt == '0, r_wp == r_rp, "pointer mismatch")
endmodule

### rtl/core/dsrp_back.sv
// Back end: tuning words, ratio compare and rounded shift-subtract division.
// Depends on dsrp_pkg and the assertion macros.
`include "dds_sweep_ramp_planner_macros.svh"
module dsrp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [29:0]    i_sysclk,
    input  logic           i_valid,
    output logic           o_take,
    input  dsrp_pkg::t_job i_job,
    output logic           o_empty,
    input  logic           i_pop,
    output dsrp_pkg::t_res o_res
);
    typedef enum logic [2:0] {
        S_IDLE, S_WS, S_WE, S_MUL, S_MULH, S_DIV, S_DONE
    } t_state;

    t_state         r_st;
    dsrp_pkg::t_job r_job;
    logic [31:0]    r_ws, r_we;
    logic [127:0]   r_n;
    logic [127:0]   r_r;
    logic [127:0]   r_d, r_q;
    logic [7:0]     r_cnt;
    logic           r_per;
    logic [31:0]    r_cap;
    logic           r_ovalid;
    dsrp_pkg::t_res r_wrk;
    dsrp_pkg::t_res r_res;
    logic [95:0]    r_base, r_want;
    logic [32:0]    w_delta;
    logic [128:0]   w_rs;
    logic [128:0]   w_sub;
    logic [31:0]    w_f;
    logic [63:0]    w_tw;
    logic [31:0]    w_word;
    logic [127:0]   w_q;
    logic [31:0]    w_sat;
    logic [30:0]    w_mop;
    logic [60:0]    w_pp;

    // tuning word uses a small divide: same shift-subtract unit
    assign w_rs  = {r_r, r_n[127]};
    assign w_sub = w_rs - {1'b0, r_d};
    assign w_delta = {1'b0, r_we} - {1'b0, r_ws};
    assign w_f   = (r_st == S_WS) ? r_job.start_f : r_job.stop_f;
    // stop frequency numerator, loaded when the start word finishes
    assign w_tw  = {r_job.stop_f, 32'd0} + 64'(i_sysclk >> 1);
    assign w_q   = {r_q[126:0], ~w_sub[128]};
    assign w_word = (w_f >= {2'b0, i_sysclk}) ? 32'hFFFFFFFF : w_q[31:0];
    // ns * sysclk in two halves of 31 bits
    assign w_mop = (r_st == S_MUL) ? r_job.ns[30:0] : r_job.ns[61:31];
    assign w_pp  = 61'(w_mop) * 61'(i_sysclk);
    always_comb begin
        if (w_q[127:32] != '0 || w_q[31:0] > r_cap) w_sat = r_cap;
        else if (w_q[31:0] == '0)                    w_sat = 32'd1;
        else                                         w_sat = w_q[31:0];
    end

    assign o_take  = (r_st == S_IDLE) && i_valid;
    assign o_empty = !r_ovalid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_pop && r_ovalid) r_ovalid <= 1'b0;
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_job <= i_job;
                    r_r   <= '0;
                    r_q   <= '0;
                    r_cnt <= 8'd63;
                    r_d   <= 128'(i_sysclk);
                    r_n   <= {i_job.start_f, 32'd0, 64'd0} + {64'(i_sysclk >> 1), 64'd0};
                    if (i_job.bad || i_sysclk == '0) begin
                        r_ws <= '0; r_we <= '0;
                        r_st <= S_MUL;
                    end else r_st <= S_WS;
                end
                S_WS, S_WE: begin
                    r_n <= {r_n[126:0], 1'b0};
                    r_q <= w_q;
                    r_r <= w_sub[128] ? w_rs[127:0] : w_sub[127:0];
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_r <= '0;
                        r_q <= '0;
                        r_cnt <= 8'd63;
                        if (r_st == S_WS) begin
                            r_ws <= (r_job.start_f == '0) ? '0 : w_word;
                            r_n  <= {w_tw, 64'd0};
                            r_st <= S_WE;
                        end else begin
                            r_we <= w_word;
                            r_st <= S_MUL;
                        end
                    end
                end
                S_MUL: begin
                    r_base <= 96'(dsrp_pkg::BASE_NS) * 96'(w_delta[31:0]);
                    r_want <= 96'(w_pp);
                    r_cnt  <= 8'd127;
                    r_r    <= '0;
                    r_q    <= '0;
                    if (r_job.bad || i_sysclk == '0 || w_delta[32] || w_delta[31:0] == '0) begin
                        r_wrk <= '{status: 1'b1, start_word: '0, end_word: '0,
                                   word_step: '0, step_period: '0, rep: r_job.rep};
                        r_st  <= S_DONE;
                    end else r_st <= S_MULH;
                end
                S_MULH: begin
                    r_want <= r_want + {4'd0, w_pp, 31'd0};
                    r_st   <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == 8'd127 && r_q == '0 && r_r == '0 && r_n != 128'd1) begin
                        // set up once: n = 2*num + den, d = 2*den
                        r_wrk <= '{status: 1'b0, start_word: r_ws, end_word: r_we,
                                   word_step: 32'd1, step_period: 16'd1, rep: r_job.rep};
                        if (r_base < r_want) begin
                            r_per <= 1'b1;
                            r_cap <= 32'(dsrp_pkg::MAX_PERIOD);
                            r_n   <= {31'd0, r_want, 1'b0} + 128'(r_base);
                            r_d   <= {31'd0, r_base, 1'b0};
                        end else if (r_want < r_base) begin
                            r_per <= 1'b0;
                            r_cap <= w_delta[31:0];
                            r_n   <= {31'd0, r_base, 1'b0} + 128'(r_want);
                            r_d   <= {31'd0, r_want, 1'b0};
                        end else begin
                            r_st <= S_DONE;
                        end
                        r_q <= 128'd1 << 127; // marker: setup done
                    end else begin
                        r_n <= {r_n[126:0], 1'b0};
                        r_q <= (r_q == 128'd1 << 127 && r_cnt == 8'd127)
                               ? {127'd0, ~w_sub[128]} : w_q;
                        r_r <= w_sub[128] ? w_rs[127:0] : w_sub[127:0];
                        r_cnt <= r_cnt - 1'b1;
                        if (r_cnt == '0) begin
                            if (r_per) r_wrk.step_period <= w_sat[15:0];
                            else       r_wrk.word_step   <= w_sat;
                            r_st <= S_DONE;
                        end
                    end
                end
                S_DONE: if (!r_ovalid || i_pop) begin
                    r_res    <= r_wrk;
                    r_ovalid <= 1'b1;
                    r_st     <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    `DSRP_ASSERT_IMP(a_bad_zero, i_clk, i_rst_n, r_ovalid && r_res.status, r_res.word_step == '0, "bad item has step")
    `DSRP_ASSERT_IMP(a_ok_step, i_clk, i_rst_n, r_ovalid && !r_res.status, r_res.word_step != '0 && r_res.step_period != '0, "zero step")
    `DSRP_ASSERT_NXT(a_take, i_clk, i_rst_n, o_take, r_st == S_WS || r_st == S_MUL, "take without start")
endmodule

### rtl/core/dds_sweep_ramp_planner.sv
// Top level of the sweep ramp planner: front end, job queue, back end.
// Depends on dsrp_pkg, dsrp_front, dsrp_queue, dsrp_back.
//
//  channel | dir | handshake        | fields
//  request | in  | push / full      | start, stop, duration, unit, repeat
//  result  | out | empty / pop      | status, words, step, period, repeat
//  config  | in  | i_sysclk_we      | i_sysclk_hz
//
// A valid request holds the back end for two 64-step divisions for the
// tuning words, a 96-bit product in S_MUL and S_MULH and one 128-step
// rounded division, one quotient bit a cycle. Requests the front screens
// out run S_MUL, then done. Front end and queue keep accepting meanwhile.
// Reset is synchronous, active low; sysclk returns to 1 GHz.
// A held result parks the back end in its done state; full rises once the
// queue and the front register both hold a waiting job.
module dds_sweep_ramp_planner #(
    parameter int unsigned QDEPTH = dsrp_pkg::QDEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_sysclk_we,
    input  logic [29:0] i_sysclk_hz,
    input  logic        push,
    output logic        full,
    input  logic [31:0] i_start_freq_hz,
    input  logic [31:0] i_stop_freq_hz,
    input  logic [31:0] i_sweep_duration,
    input  logic [1:0]  i_time_unit,
    input  logic        i_repeat_sweep,
    output logic        empty,
    input  logic        pop,
    output logic        o_status,
    output logic [31:0] o_start_word,
    output logic [31:0] o_end_word,
    output logic [31:0] o_word_step,
    output logic [15:0] o_step_period,
    output logic        o_repeat_out
);
    logic [29:0]    r_sysclk;
    logic           w_fvalid, w_qready, w_qvalid, w_take;
    dsrp_pkg::t_job w_fjob, w_qjob;
    dsrp_pkg::t_res w_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sysclk <= 30'(dsrp_pkg::SYSCLK_RESET);
        else if (i_sysclk_we) r_sysclk <= i_sysclk_hz;
    end

    dsrp_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .o_full(full),
        .i_start_freq_hz, .i_stop_freq_hz, .i_sweep_duration, .i_time_unit,
        .i_repeat_sweep, .o_valid(w_fvalid), .i_ready(w_qready), .o_job(w_fjob)
    );

    dsrp_queue #(.DEPTH(QDEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_wr(w_fvalid), .i_data(w_fjob), .o_ready(w_qready),
        .o_valid(w_qvalid), .i_rd(w_take), .o_data(w_qjob)
    );

    dsrp_back u_back (
        .i_clk, .i_rst_n, .i_sysclk(r_sysclk), .i_valid(w_qvalid), .o_take(w_take),
        .i_job(w_qjob), .o_empty(empty), .i_pop(pop), .o_res(w_res)
    );

    assign o_status      = w_res.status;
    assign o_start_word  = w_res.start_word;
    assign o_end_word    = w_res.end_word;
    assign o_word_step   = w_res.word_step;
    assign o_step_period = w_res.step_period;
    assign o_repeat_out  = w_res.rep;
endmodule

### dv/dds_sweep_ramp_planner_checker.sv
// Scoreboard for the sweep ramp planner: predicts each request's ramp settings.
// Depends on dsrp_pkg; instantiated beside the block by dds_sweep_ramp_planner_tb.
module dds_sweep_ramp_planner_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_sysclk_we,
    input  logic [29:0] i_sysclk_hz,
    input  logic        push,
    input  logic        full,
    input  logic [31:0] i_start_freq_hz,
    input  logic [31:0] i_stop_freq_hz,
    input  logic [31:0] i_sweep_duration,
    input  logic [1:0]  i_time_unit,
    input  logic        i_repeat_sweep,
    input  logic        empty,
    input  logic        pop,
    input  logic        o_status,
    input  logic [31:0] o_start_word,
    input  logic [31:0] o_end_word,
    input  logic [31:0] o_word_step,
    input  logic [15:0] o_step_period,
    input  logic        o_repeat_out,
    output int          o_pending,
    output int          o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [29:0]    sysclk_hz;
    dsrp_pkg::t_res plans_due[$];

    function automatic logic [31:0] tuning_word(logic [31:0] f, logic [29:0] sys);
        if (sys == 0 || f == 0) return 32'hFFFF_FFFF & 32'd0;
        if (f >= {2'b00, sys}) return 32'hFFFF_FFFF;
        return 32'(((64'(f) << 32) + 64'(sys >> 1)) / 64'(sys));
    endfunction

    // half-up rounded ratio, clamped to 1..cap
    function automatic logic [63:0] round_ratio(logic [127:0] num, logic [127:0] den,
                                                logic [63:0] cap);
        logic [129:0] q;
        q = ({1'b0, num, 1'b0} + 130'(den)) / {1'b0, den, 1'b0};
        if (q > 130'(cap)) return cap;
        if (q == 0) return 64'd1;
        return q[63:0];
    endfunction

    function automatic dsrp_pkg::t_res plan_sweep(logic [31:0] f0, logic [31:0] f1,
                                                  logic [31:0] dur, logic [1:0] unit,
                                                  logic rep, logic [29:0] sys);
        dsrp_pkg::t_res res;
        logic [63:0]    ns, ws, we, delta;
        logic [127:0]   base, want;
        res = '0;
        res.status = 1'b1;
        res.rep = rep;
        if (dur == 0 || f0 == 0 || f1 == 0 || f1 <= f0) return res;
        case (dsrp_pkg::t_unit'(unit))
            dsrp_pkg::UNIT_S:  ns = 64'(dur) * 64'd1000000000;
            dsrp_pkg::UNIT_MS: ns = 64'(dur) * 64'd1000000;
            dsrp_pkg::UNIT_US: ns = 64'(dur) * 64'd1000;
            default:           ns = 64'(dur);
        endcase
        ws = 64'(tuning_word(f0, sys));
        we = 64'(tuning_word(f1, sys));
        delta = (we - ws) & 64'hFFFF_FFFF;
        if (delta == 0 || sys == 0) return res;
        base = 128'(dsrp_pkg::BASE_NS) * 128'(delta);
        want = 128'(ns) * 128'(sys);
        res.status = 1'b0;
        res.start_word = ws[31:0];
        res.end_word = we[31:0];
        res.word_step = 32'd1;
        res.step_period = 16'd1;
        if (base < want)
            res.step_period = 16'(round_ratio(want, base, 64'(dsrp_pkg::MAX_PERIOD)));
        else if (want < base)
            res.word_step = 32'(round_ratio(base, want, delta));
        return res;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $time, field, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;
    assign o_pending = plans_due.size();

    always @(posedge i_clk) begin
        dsrp_pkg::t_res due;
        if (!i_rst_n) begin
            sysclk_hz <= 30'(dsrp_pkg::SYSCLK_RESET);
            plans_due.delete();
        end else begin
            if (i_sysclk_we)
                sysclk_hz <= i_sysclk_hz;
            if (push && !full)
                plans_due.push_back(plan_sweep(i_start_freq_hz, i_stop_freq_hz,
                    i_sweep_duration, i_time_unit, i_repeat_sweep, sysclk_hz));
            if (pop && !empty) begin
                if (plans_due.size() == 0) begin
                    report_mismatch("unexpected transfer", 32'd0, 32'd0);
                end else begin
                    due = plans_due.pop_front();
                    if (o_status !== due.status)
                        report_mismatch("status", 32'(o_status), 32'(due.status));
                    if (o_start_word !== due.start_word)
                        report_mismatch("start_word", o_start_word, due.start_word);
                    if (o_end_word !== due.end_word)
                        report_mismatch("end_word", o_end_word, due.end_word);
                    if (o_word_step !== due.word_step)
                        report_mismatch("word_step", o_word_step, due.word_step);
                    if (o_step_period !== due.step_period)
                        report_mismatch("step_period", 32'(o_step_period),
                                        32'(due.step_period));
                    if (o_repeat_out !== due.rep)
                        report_mismatch("repeat_out", 32'(o_repeat_out), 32'(due.rep));
                end
            end
        end
    end
endmodule

### dv/dds_sweep_ramp_planner_tb.sv
// Top of the sweep ramp planner testbench: clock, reset, requests, pop pacing, verdict.
// Depends on dsrp_pkg, dds_sweep_ramp_planner and dds_sweep_ramp_planner_checker.
module dds_sweep_ramp_planner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_sysclk_we = 1'b0;
    logic [29:0] i_sysclk_hz = '0;
    logic        push = 1'b0;
    logic        full;
    logic [31:0] i_start_freq_hz = '0;
    logic [31:0] i_stop_freq_hz = '0;
    logic [31:0] i_sweep_duration = '0;
    logic [1:0]  i_time_unit = dsrp_pkg::UNIT_S;
    logic        i_repeat_sweep = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_status;
    logic [31:0] o_start_word, o_end_word, o_word_step;
    logic [15:0] o_step_period;
    logic        o_repeat_out;
    int          pending, errors;
    int          popped = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    dds_sweep_ramp_planner dut (.*);
    dds_sweep_ramp_planner_checker scoreboard (.*, .o_pending(pending), .o_errors(errors));

    // mostly back-to-back, sometimes a short pause, rarely a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 4);
        return $urandom_range(20, 400);
    endfunction

    task automatic send_request(logic [31:0] f0, logic [31:0] f1, logic [31:0] dur,
                                dsrp_pkg::t_unit unit, logic rep);
        int g;
        i_start_freq_hz  <= f0;
        i_stop_freq_hz   <= f1;
        i_sweep_duration <= dur;
        i_time_unit      <= unit;
        i_repeat_sweep   <= rep;
        push <= 1'b1;
        do @(posedge i_clk); while (full);
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // block must be drained before the clock register changes
    task automatic write_sysclk(logic [29:0] hz);
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        i_sysclk_hz <= hz;
        i_sysclk_we <= 1'b1;
        @(posedge i_clk);
        i_sysclk_we <= 1'b0;
    endtask

    // Random request: mostly well-formed sweeps below the system clock, with
    // durations spread over many decades so both stretch and step paths show.
    task automatic send_random(logic [29:0] sys);
        logic [31:0] a, b, dur;
        int          r;
        r = $urandom_range(0, 99);
        a = $urandom;
        b = $urandom;
        dur = $urandom >> $urandom_range(0, 31);
        if (r < 75 && sys > 2) begin
            a = $urandom_range(1, sys - 2);
            b = $urandom_range(a + 1, sys - 1);
            if ($urandom_range(0, 3) == 0) a = b - $urandom_range(1, 16) > 0 ?
                b - $urandom_range(1, 16) : 1;
        end else if (r < 85) begin
            if (b < a) {a, b} = {b, a};
        end else if (r < 90) begin
            dur = 0;
        end
        if (a == 0 && r < 85) a = 1;
        if (b <= a && r < 85) b = a + 1;
        send_request(a, b, dur, dsrp_pkg::t_unit'($urandom_range(0, 3)), 1'($urandom));
    endtask

    // Pop pacing: free-running or random stretches, picked at random, plus one long
    // hold-off once traffic is flowing so the queue fills and the input stalls.
    always @(posedge i_clk) begin
        int hold, mode_left;
        bit held_once, eager;
        if (i_rst_n) begin
            if (pop && !empty) popped++;
            if (mode_left == 0) begin
                eager = $urandom_range(0, 2) == 0;
                mode_left = 256;
            end
            mode_left--;
            if (!held_once && popped >= 150) begin
                held_once = 1;
                hold = 3000;
            end
            if (hold > 0) begin
                hold--;
                pop <= 1'b0;
            end else if (eager) begin
                pop <= 1'b1;
            end else begin
                pop <= gap_len() == 0 ? 1'b1 : 1'b0;
            end
        end
    end

    initial begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [29:0] clocks[6];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, 1 GHz reset clock; 1953125 Hz is exactly word 2^23
        send_request(32'd1000, 32'd2000, 32'd0, dsrp_pkg::UNIT_S, 1'b1);    // no duration
        send_request(32'd0, 32'd2000, 32'd5, dsrp_pkg::UNIT_MS, 1'b0);      // no start
        send_request(32'd1000, 32'd0, 32'd5, dsrp_pkg::UNIT_US, 1'b1);      // no stop
        send_request(32'd7000, 32'd7000, 32'd5, dsrp_pkg::UNIT_NS, 1'b0);   // flat sweep
        send_request(32'd9000, 32'd7000, 32'd5, dsrp_pkg::UNIT_NS, 1'b1);   // falling sweep
        send_request(32'd1000000000, 32'd2000000000, 32'd5, dsrp_pkg::UNIT_S,
                     1'b0);                                                 // both saturate
        send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, dsrp_pkg::UNIT_S, 1'b1);
        send_request(32'd1953125, 32'd3906250, 32'd33554432, dsrp_pkg::UNIT_NS,
                     1'b0);                                                 // equal to base
        send_request(32'd1953125, 32'd3906250, 32'd33554431, dsrp_pkg::UNIT_NS, 1'b1);
        send_request(32'd1953125, 32'd3906250, 32'd33554433, dsrp_pkg::UNIT_NS, 1'b0);
        send_request(32'd1, 32'd999999999, 32'd1, dsrp_pkg::UNIT_NS, 1'b1); // step clamps
        send_request(32'd1, 32'd2, 32'hFFFF_FFFF, dsrp_pkg::UNIT_S, 1'b0);  // period clamps
        send_request(32'd1, 32'd2, 32'd1, dsrp_pkg::UNIT_US, 1'b1);
        send_request(32'd100, 32'd500000000, 32'd3, dsrp_pkg::UNIT_MS, 1'b0);
        send_request(32'd100, 32'd500000000, 32'd3, dsrp_pkg::UNIT_US, 1'b1);
        send_request(32'd1, 32'hFFFF_FFFF, 32'd10, dsrp_pkg::UNIT_S, 1'b0);
        send_request(32'd999999998, 32'd999999999, 32'd1, dsrp_pkg::UNIT_S, 1'b1);

        clocks = '{30'd1000000000, 30'd0, 30'd1, 30'h3FFF_FFFF, 30'd125000000, 30'd1000000000};
        foreach (clocks[k]) begin
            write_sysclk(k == 5 ? 30'($urandom_range(1000, 1073741823)) : clocks[k]);
            repeat (k == 1 || k == 2 ? 40 : 260) send_random(k == 5 ? 30'd0 : clocks[k]);
        end
        push <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
